// ===== src/rsta_pkg.sv =====
// ----------------------------------------------------------------------------
// Request slot table arbiter: shared definitions
// Operation, result and slot status codes, field widths and the command word
// passed from the front end to the slot engine.
// ----------------------------------------------------------------------------
package rsta_pkg;

    localparam int OP_W     = 2;
    localparam int SKIND_W  = 2;
    localparam int INDEX_W  = 4;
    localparam int CAP_W    = 5;
    localparam int STATUS_W = 2;
    localparam int SEQ_W    = 32;
    localparam int SSTAT_W  = 2;

    localparam int CAP_RESET = 15;

    // operations
    localparam logic [OP_W-1:0] OP_ARRIVE  = 2'd0;
    localparam logic [OP_W-1:0] OP_PICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH  = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] RS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] RS_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] RS_ABSENT  = 2'd2;

    // per-slot status
    localparam logic [SSTAT_W-1:0] SS_WAITING = 2'd0;
    localparam logic [SSTAT_W-1:0] SS_SERVING = 2'd1;
    localparam logic [SSTAT_W-1:0] SS_OK      = 2'd2;
    localparam logic [SSTAT_W-1:0] SS_FAULT   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic               req_kind;
        logic               any_kind;
        logic               pick_kind;
        logic [INDEX_W-1:0] slot_index;
        logic               fault;
    } cmd_t;

endpackage

// ===== src/rsta_front.sv =====
// ----------------------------------------------------------------------------
// Request slot table arbiter: front end
// Takes input words, decodes the server class and holds up to two commands
// for the slot engine.
// ----------------------------------------------------------------------------
module rsta_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rsta_pkg::OP_W-1:0]         s_opcode,
    input  logic                              s_request_kind,
    input  logic [rsta_pkg::SKIND_W-1:0]      s_server_kind,
    input  logic [rsta_pkg::INDEX_W-1:0]      s_slot_index,
    input  logic                              s_outcome_fault,
    output logic                              q_valid,
    output rsta_pkg::cmd_t                    q_cmd,
    input  logic                              q_pop
);

    rsta_pkg::cmd_t entry_reg [2];
    rsta_pkg::cmd_t cmd_in;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;
    logic           push;

    // server kinds two and three both take either kind
    always_comb begin
        cmd_in.opcode     = s_opcode;
        cmd_in.req_kind   = s_request_kind;
        cmd_in.any_kind   = s_server_kind[1];
        cmd_in.pick_kind  = s_server_kind[0];
        cmd_in.slot_index = s_slot_index;
        cmd_in.fault      = s_outcome_fault;
    end

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, q_pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty command queue");

endmodule

// ===== src/rsta_back.sv =====
// ----------------------------------------------------------------------------
// Request slot table arbiter: slot engine
// Runs one command at a time over the slot table: free-slot scan for arrive,
// oldest-first scan for pick, single read for finish and release.
// ----------------------------------------------------------------------------
module rsta_back #(
    parameter int SLOTS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [$clog2(SLOTS+1)-1:0]          cap,
    input  logic                                q_valid,
    input  rsta_pkg::cmd_t                      q_cmd,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rsta_pkg::STATUS_W-1:0]       m_status_code,
    output logic [rsta_pkg::INDEX_W-1:0]        m_granted_slot,
    output logic [rsta_pkg::SEQ_W-1:0]          m_sequence_number
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS+1);
    localparam int SEQ_W  = rsta_pkg::SEQ_W;
    localparam int SS_W   = rsta_pkg::SSTAT_W;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_ARR_SCAN   = 3'd1;
    localparam logic [2:0] S_PICK_SCAN  = 3'd2;
    localparam logic [2:0] S_PICK_DRAIN = 3'd3;
    localparam logic [2:0] S_PICK_DONE  = 3'd4;
    localparam logic [2:0] S_IDX_READ   = 3'd5;
    localparam logic [2:0] S_IDX_DONE   = 3'd6;

    logic [2:0]        state_reg, state_next;
    rsta_pkg::cmd_t    cmd_reg, cmd_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SEQ_W-1:0]  arrivals_reg, arrivals_next;

    logic              own_found_reg, own_found_next;
    logic [SLOT_W-1:0] own_idx_reg, own_idx_next;
    logic [SEQ_W-1:0]  own_age_reg, own_age_next;
    logic [SEQ_W-1:0]  own_seq_reg, own_seq_next;
    logic              oth_found_reg, oth_found_next;
    logic [SLOT_W-1:0] oth_idx_reg, oth_idx_next;
    logic [SEQ_W-1:0]  oth_age_reg, oth_age_next;
    logic [SEQ_W-1:0]  oth_seq_reg, oth_seq_next;

    logic              out_valid_reg, out_valid_next;
    logic [rsta_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [rsta_pkg::INDEX_W-1:0]  out_slot_reg, out_slot_next;
    logic [SEQ_W-1:0]  out_seq_reg, out_seq_next;

    // slot store
    logic              kind_mem   [SLOTS];
    logic [SS_W-1:0]   status_mem [SLOTS];
    logic [SEQ_W-1:0]  seq_mem    [SLOTS];

    logic              rd_live_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic              rd_kind_reg;
    logic [SS_W-1:0]   rd_status_reg;
    logic [SEQ_W-1:0]  rd_seq_reg;

    logic              we_entry;
    logic              we_status;
    logic [SS_W-1:0]   wr_status;
    logic [SLOT_W-1:0] wr_addr;
    logic [SEQ_W-1:0]  arrivals_inc;

    logic              eligible;
    logic              own_kind;
    logic [SEQ_W-1:0]  age;
    logic              own_take;
    logic              oth_take;
    logic              in_range;
    logic              hit;

    assign arrivals_inc = arrivals_reg + 32'd1;
    assign in_range     = (32'(cmd_reg.slot_index) < 32'(SLOTS));
    assign hit          = in_range && rd_valid_reg;

    // age comparison on the word read out in the previous cycle
    assign eligible = rd_live_reg && rd_valid_reg && (rd_status_reg == rsta_pkg::SS_WAITING);
    assign own_kind = cmd_reg.any_kind || (rd_kind_reg == cmd_reg.pick_kind);
    assign age      = arrivals_reg - rd_seq_reg;
    assign own_take = eligible && own_kind && (!own_found_reg || (age > own_age_reg));
    assign oth_take = eligible && !own_kind && (!oth_found_reg || (age > oth_age_reg));

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        arrivals_next   = arrivals_reg;
        own_found_next  = own_found_reg;
        own_idx_next    = own_idx_reg;
        own_age_next    = own_age_reg;
        own_seq_next    = own_seq_reg;
        oth_found_next  = oth_found_reg;
        oth_idx_next    = oth_idx_reg;
        oth_age_next    = oth_age_reg;
        oth_seq_next    = oth_seq_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_seq_next    = out_seq_reg;
        q_pop           = 1'b0;
        we_entry        = 1'b0;
        we_status       = 1'b0;
        wr_status       = rsta_pkg::SS_WAITING;
        wr_addr         = idx_reg;

        if (own_take) begin
            own_found_next = 1'b1;
            own_idx_next   = rd_idx_reg;
            own_age_next   = age;
            own_seq_next   = rd_seq_reg;
        end
        if (oth_take) begin
            oth_found_next = 1'b1;
            oth_idx_next   = rd_idx_reg;
            oth_age_next   = age;
            oth_seq_next   = rd_seq_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && (!out_valid_reg || m_ready)) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    idx_next = '0;
                    unique case (q_cmd.opcode)
                        rsta_pkg::OP_ARRIVE: begin
                            if (count_reg >= cap) begin
                                out_valid_next  = 1'b1;
                                out_status_next = rsta_pkg::RS_REFUSED;
                                out_slot_next   = '0;
                                out_seq_next    = '0;
                            end else begin
                                state_next = S_ARR_SCAN;
                            end
                        end
                        rsta_pkg::OP_PICK: begin
                            own_found_next = 1'b0;
                            oth_found_next = 1'b0;
                            state_next     = S_PICK_SCAN;
                        end
                        default: begin
                            idx_next   = SLOT_W'(q_cmd.slot_index);
                            state_next = S_IDX_READ;
                        end
                    endcase
                end
            end
            S_ARR_SCAN: begin
                if (CNT_W'(idx_reg) >= cap) begin
                    out_valid_next  = 1'b1;
                    out_status_next = rsta_pkg::RS_REFUSED;
                    out_slot_next   = '0;
                    out_seq_next    = '0;
                    state_next      = S_IDLE;
                end else if (!valid_reg[idx_reg]) begin
                    we_entry            = 1'b1;
                    we_status           = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    count_next          = count_reg + 1'b1;
                    arrivals_next       = arrivals_inc;
                    out_valid_next      = 1'b1;
                    out_status_next     = rsta_pkg::RS_DONE;
                    out_slot_next       = rsta_pkg::INDEX_W'(idx_reg);
                    out_seq_next        = arrivals_inc;
                    state_next          = S_IDLE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_PICK_SCAN: begin
                if (idx_reg == SLOT_W'(SLOTS - 1)) begin
                    state_next = S_PICK_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_PICK_DRAIN: begin
                state_next = S_PICK_DONE;
            end
            S_PICK_DONE: begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                wr_status      = rsta_pkg::SS_SERVING;
                if (own_found_reg) begin
                    we_status       = 1'b1;
                    wr_addr         = own_idx_reg;
                    out_status_next = rsta_pkg::RS_DONE;
                    out_slot_next   = rsta_pkg::INDEX_W'(own_idx_reg);
                    out_seq_next    = own_seq_reg;
                end else if (oth_found_reg) begin
                    we_status       = 1'b1;
                    wr_addr         = oth_idx_reg;
                    out_status_next = rsta_pkg::RS_DONE;
                    out_slot_next   = rsta_pkg::INDEX_W'(oth_idx_reg);
                    out_seq_next    = oth_seq_reg;
                end else begin
                    out_status_next = rsta_pkg::RS_REFUSED;
                    out_slot_next   = '0;
                    out_seq_next    = '0;
                end
            end
            S_IDX_READ: begin
                state_next = S_IDX_DONE;
            end
            S_IDX_DONE: begin
                out_valid_next = 1'b1;
                out_slot_next  = cmd_reg.slot_index;
                state_next     = S_IDLE;
                if (hit) begin
                    out_status_next = rsta_pkg::RS_DONE;
                    out_seq_next    = rd_seq_reg;
                    if (cmd_reg.opcode == rsta_pkg::OP_FINISH) begin
                        we_status = 1'b1;
                        wr_status = cmd_reg.fault ? rsta_pkg::SS_FAULT : rsta_pkg::SS_OK;
                    end else begin
                        valid_next[idx_reg] = 1'b0;
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end else begin
                    out_status_next = rsta_pkg::RS_ABSENT;
                    out_seq_next    = '0;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            arrivals_reg  <= '0;
            out_valid_reg <= 1'b0;
            rd_live_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            arrivals_reg  <= arrivals_next;
            out_valid_reg <= out_valid_next;
            rd_live_reg   <= (state_reg == S_PICK_SCAN);
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        own_found_reg  <= own_found_next;
        own_idx_reg    <= own_idx_next;
        own_age_reg    <= own_age_next;
        own_seq_reg    <= own_seq_next;
        oth_found_reg  <= oth_found_next;
        oth_idx_reg    <= oth_idx_next;
        oth_age_reg    <= oth_age_next;
        oth_seq_reg    <= oth_seq_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_seq_reg    <= out_seq_next;
        rd_valid_reg   <= valid_reg[idx_reg];
        rd_idx_reg     <= idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (we_entry) begin
            kind_mem[wr_addr] <= cmd_reg.req_kind;
            seq_mem[wr_addr]  <= arrivals_inc;
        end
        if (we_status) begin
            status_mem[wr_addr] <= wr_status;
        end
        rd_kind_reg   <= kind_mem[idx_reg];
        rd_status_reg <= status_mem[idx_reg];
        rd_seq_reg    <= seq_mem[idx_reg];
    end

    assign m_valid           = out_valid_reg;
    assign m_status_code     = out_status_reg;
    assign m_granted_slot    = out_slot_reg;
    assign m_sequence_number = out_seq_reg;

    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("occupied count out of step with valid bits");

    a_pop_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!out_valid_reg || m_ready))
        else $error("command started with result word still held");

    a_busy_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result word pending while a command is in progress");

endmodule

// ===== src/request_slot_table_arbiter.sv =====
// ----------------------------------------------------------------------------
// Request slot table arbiter
// Slot table with arrive, oldest-first pick, finish and release commands.
//
//   channel  | handshake          | word
//   ---------+--------------------+--------------------------------------------
//   cfg      | cfg_valid/ready    | cfg_data: capacity
//   s        | s_valid/s_ready    | opcode, request_kind, server_kind,
//            |                    | slot_index, outcome_fault
//   m        | m_valid/m_ready    | status_code, granted_slot, sequence_number
//
// One command is worked at a time; the two-entry queue takes new words
// while the engine is busy or the result word waits.
// Arrive: refused at once when the table already holds capacity entries, else a
// free-slot scan over the first capacity slots. Pick: one slot read per cycle from
// the slot store over all SLOTS slots. Finish/release: a single indexed read.
// Reset clears the valid bits, counters and queue; capacity returns to min(SLOTS, 15).
// ----------------------------------------------------------------------------
module request_slot_table_arbiter #(
    parameter int SLOTS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsta_pkg::CAP_W-1:0]          cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rsta_pkg::OP_W-1:0]           s_opcode,
    input  logic                                s_request_kind,
    input  logic [rsta_pkg::SKIND_W-1:0]        s_server_kind,
    input  logic [rsta_pkg::INDEX_W-1:0]        s_slot_index,
    input  logic                                s_outcome_fault,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rsta_pkg::STATUS_W-1:0]       m_status_code,
    output logic [rsta_pkg::INDEX_W-1:0]        m_granted_slot,
    output logic [rsta_pkg::SEQ_W-1:0]          m_sequence_number
);

    localparam int CNT_W     = $clog2(SLOTS+1);
    localparam int CAP_RESET = (SLOTS < rsta_pkg::CAP_RESET) ? SLOTS : rsta_pkg::CAP_RESET;

    logic [CNT_W-1:0] cap_reg, cap_next;
    logic             q_valid;
    logic             q_pop;
    rsta_pkg::cmd_t   q_cmd;

    assign cfg_ready = 1'b1;

    // capacity held already clipped to the table size
    always_comb begin
        cap_next = cap_reg;
        if (cfg_valid) begin
            if (32'(cfg_data) > 32'(SLOTS)) begin
                cap_next = CNT_W'(SLOTS);
            end else begin
                cap_next = CNT_W'(cfg_data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CNT_W'(CAP_RESET);
        end else begin
            cap_reg <= cap_next;
        end
    end

    rsta_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_request_kind  (s_request_kind),
        .s_server_kind   (s_server_kind),
        .s_slot_index    (s_slot_index),
        .s_outcome_fault (s_outcome_fault),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_pop           (q_pop)
    );

    rsta_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cap               (cap_reg),
        .q_valid           (q_valid),
        .q_cmd             (q_cmd),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status_code     (m_status_code),
        .m_granted_slot    (m_granted_slot),
        .m_sequence_number (m_sequence_number)
    );

endmodule
